[rtl/obc_pkg.sv]
// ============================================================================
// obc_pkg
// Shared types and constants of the oriented box corner and bounds core.
// ============================================================================
package obc_pkg;

    // pipeline depth, split between the trig front end and the corner back end
    localparam int SC_STAGES   = 5;
    localparam int CN_STAGES   = 5;
    localparam int PIPE_STAGES = SC_STAGES + CN_STAGES;

    // quarter-wave polynomial, Q1.30
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [30:0] POLY_A  = 31'd1686629713;
    localparam logic [29:0] POLY_B  = 30'd688904866;
    localparam logic [26:0] POLY_C  = 27'd76016977;

    // corner codes, local box order
    localparam logic [1:0] CORNER_BL = 2'd0;
    localparam logic [1:0] CORNER_BR = 2'd1;
    localparam logic [1:0] CORNER_TR = 2'd2;
    localparam logic [1:0] CORNER_TL = 2'd3;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]        hw;
        logic [30:0]        hh;
    } t_geom;

    // first-quadrant sine/cosine in Q2.14 plus the quadrant
    typedef struct packed {
        logic [1:0]  quad;
        logic [15:0] s0;
        logic [15:0] c0;
    } t_trig;

    typedef struct packed {
        logic [3:0][31:0] wx;
        logic [3:0][31:0] wy;
        logic [31:0]      min_x;
        logic [31:0]      min_y;
        logic [31:0]      max_x;
        logic [31:0]      max_y;
        logic [15:0]      nx0;
        logic [15:0]      ny0;
        logic [15:0]      nx1;
        logic [15:0]      ny1;
    } t_box_res;

    typedef struct packed {
        logic [PIPE_STAGES-1:0] en;     // per-stage load enable
        logic                   valid;  // last stage holds a box
    } t_pipe_ctl;

endpackage

[rtl/obc_if.sv]
// ============================================================================
// obc_box_if / obc_corner_if
// Valid/ready channels for box transactions in and corner transactions out.
// ============================================================================
interface obc_box_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic [15:0]        angle;
    logic [30:0]        half_width;
    logic [30:0]        half_height;

    modport source (output valid, centre_x, centre_y, angle, half_width, half_height,
                    input ready);
    modport sink   (input valid, centre_x, centre_y, angle, half_width, half_height,
                    output ready);
endinterface

interface obc_corner_if;
    logic               valid;
    logic               ready;
    logic [1:0]         corner_index;
    logic signed [31:0] corner_x;
    logic signed [31:0] corner_y;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [31:0] bound_min_x;
    logic signed [31:0] bound_min_y;
    logic signed [31:0] bound_max_x;
    logic signed [31:0] bound_max_y;
    logic               last;

    modport source (output valid, corner_index, corner_x, corner_y, normal_x, normal_y,
                    bound_min_x, bound_min_y, bound_max_x, bound_max_y, last,
                    input ready);
    modport sink   (input valid, corner_index, corner_x, corner_y, normal_x, normal_y,
                    bound_min_x, bound_min_y, bound_max_x, bound_max_y, last,
                    output ready);
endinterface

[rtl/oriented_box_corners_and_bounds_core.sv]
// ============================================================================
// oriented_box_corners_and_bounds_core
// 2D oriented box to four world corners, edge normals and axis-aligned bounds.
// ============================================================================
// Each box transaction (Q16.16 centre, binary angle, half extents) yields four
// corner transactions in the order bl, br, tr, tl; the first two also carry
// the rotated edge normals in Q2.14 and all four carry the box bounds over the
// saturated corners, with last set on the fourth. While the output register
// holds a box, it takes the next one only with the last of its four beats.
// From box acceptance to the first corner a box passes 10 pipeline stages
// (sine/cosine polynomial, rotation, rounding and saturation, bounds tree) and
// the output register. The input is taken every cycle while the pipeline has
// room, so up to ten boxes queue up behind a stalled output.
// ============================================================================
module oriented_box_corners_and_bounds_core #(
    parameter int ANGLE_BITS = 16   // a full turn is 2^ANGLE_BITS, 8..24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    obc_box_if.sink      i_box,
    obc_corner_if.source o_corner
);
    import obc_pkg::*;

    t_pipe_ctl w_ctl;
    t_geom     w_geom_in;
    t_geom     w_geom_sc;
    t_trig     w_trig;
    t_box_res  w_res;
    logic      w_take;

    assign w_geom_in.cx = i_box.centre_x;
    assign w_geom_in.cy = i_box.centre_y;
    assign w_geom_in.hw = i_box.half_width;
    assign w_geom_in.hh = i_box.half_height;

    // valid bits and stall: a bubble anywhere downstream lets a stage load
    obc_pipe_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_box.valid),
        .i_take     (w_take),
        .o_in_ready (i_box.ready),
        .o_ctl      (w_ctl)
    );

    // stages 0..4: quarter-wave sine and cosine
    obc_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_sincos (
        .i_clk   (i_clk),
        .i_en    (w_ctl.en[SC_STAGES-1:0]),
        .i_angle (i_box.angle),
        .i_geom  (w_geom_in),
        .o_trig  (w_trig),
        .o_geom  (w_geom_sc)
    );

    // stages 5..9: corners, saturation and bounds
    obc_corner u_corner (
        .i_clk  (i_clk),
        .i_en   (w_ctl.en[PIPE_STAGES-1:SC_STAGES]),
        .i_trig (w_trig),
        .i_geom (w_geom_sc),
        .o_res  (w_res)
    );

    // output register, four corner transactions per box
    obc_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_ctl.valid),
        .i_res    (w_res),
        .o_take   (w_take),
        .o_corner (o_corner)
    );

endmodule

[rtl/obc_pipe_ctl.sv]
// ============================================================================
// obc_pipe_ctl
// Valid bits and per-stage load enables of the box pipeline.
// ============================================================================
module obc_pipe_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_take,
    output logic               o_in_ready,
    output obc_pkg::t_pipe_ctl o_ctl
);
    import obc_pkg::*;

    logic [PIPE_STAGES-1:0] r_valid;
    logic [PIPE_STAGES-1:0] n_valid;
    logic [PIPE_STAGES-1:0] w_rdy;

    // a stage may load if the tail drains or any stage from here on is empty
    for (genvar i = 0; i < PIPE_STAGES; i++) begin : g_rdy
        assign w_rdy[i] = i_take | ~(&r_valid[PIPE_STAGES-1:i]);
    end

    always_comb begin
        n_valid = r_valid;
        if (w_rdy[0]) begin
            n_valid[0] = i_in_valid;
        end
        for (int i = 1; i < PIPE_STAGES; i++) begin
            if (w_rdy[i]) begin
                n_valid[i] = r_valid[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = w_rdy[0];
    assign o_ctl.en    = w_rdy;
    assign o_ctl.valid = r_valid[PIPE_STAGES-1];

endmodule

[rtl/obc_sincos.sv]
// ============================================================================
// obc_sincos
// Five-stage quarter-wave polynomial: first-quadrant sine and cosine, Q2.14.
// ============================================================================
module obc_sincos #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic [obc_pkg::SC_STAGES-1:0] i_en,
    input  logic [15:0]                  i_angle,
    input  obc_pkg::t_geom               i_geom,
    output obc_pkg::t_trig               o_trig,
    output obc_pkg::t_geom               o_geom
);
    import obc_pkg::*;

    logic [ANGLE_BITS+15:0] w_ang_ext;
    logic [ANGLE_BITS-1:0]  w_ang;
    logic [30:0]            n_xs;
    logic [30:0]            n_xc;

    logic [30:0] r_xs [4];
    logic [30:0] r_xc [4];
    logic [1:0]  r_quad [SC_STAGES];
    t_geom       r_geom [SC_STAGES];

    logic [61:0] w_mx2s, w_mx2c;
    logic [30:0] r_x2s1, r_x2c1, r_x2s2, r_x2c2;
    logic [57:0] w_mts, w_mtc;
    logic [29:0] r_us, r_uc;
    logic [60:0] w_mvs, w_mvc;
    logic [30:0] r_ws, r_wc;
    logic [61:0] w_mps, w_mpc;
    logic [32:0] w_rs, w_rc;
    logic [15:0] r_sq, r_cq;

    // angle bits above ANGLE_BITS are dropped, missing ones read as zero
    assign w_ang_ext = {{ANGLE_BITS{1'b0}}, i_angle};
    assign w_ang     = w_ang_ext[ANGLE_BITS-1:0];
    assign n_xs      = 31'({w_ang[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}});
    assign n_xc      = Q30_ONE - n_xs;

    // x^2
    assign w_mx2s = 62'(r_xs[0]) * 62'(r_xs[0]);
    assign w_mx2c = 62'(r_xc[0]) * 62'(r_xc[0]);
    // B - C*x^2
    assign w_mts  = 58'(POLY_C) * 58'(r_x2s1);
    assign w_mtc  = 58'(POLY_C) * 58'(r_x2c1);
    // A - u*x^2
    assign w_mvs  = 61'(r_us) * 61'(r_x2s2);
    assign w_mvc  = 61'(r_uc) * 61'(r_x2c2);
    // w*x, then round to Q2.14
    assign w_mps  = 62'(r_ws) * 62'(r_xs[3]);
    assign w_mpc  = 62'(r_wc) * 62'(r_xc[3]);
    assign w_rs   = {1'b0, w_mps[61:30]} + 33'd32768;
    assign w_rc   = {1'b0, w_mpc[61:30]} + 33'd32768;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_xs[0]   <= n_xs;
            r_xc[0]   <= n_xc;
            r_quad[0] <= w_ang[ANGLE_BITS-1 -: 2];
            r_geom[0] <= i_geom;
        end
        for (int k = 1; k < SC_STAGES; k++) begin
            if (i_en[k]) begin
                r_quad[k] <= r_quad[k-1];
                r_geom[k] <= r_geom[k-1];
            end
        end
        for (int k = 1; k < 4; k++) begin
            if (i_en[k]) begin
                r_xs[k] <= r_xs[k-1];
                r_xc[k] <= r_xc[k-1];
            end
        end
        if (i_en[1]) begin
            r_x2s1 <= w_mx2s[60:30];
            r_x2c1 <= w_mx2c[60:30];
        end
        if (i_en[2]) begin
            r_us   <= POLY_B - {2'b00, w_mts[57:30]};
            r_uc   <= POLY_B - {2'b00, w_mtc[57:30]};
            r_x2s2 <= r_x2s1;
            r_x2c2 <= r_x2c1;
        end
        if (i_en[3]) begin
            r_ws <= POLY_A - w_mvs[60:30];
            r_wc <= POLY_A - w_mvc[60:30];
        end
        if (i_en[4]) begin
            r_sq <= w_rs[31:16];
            r_cq <= w_rc[31:16];
        end
    end

    assign o_trig.quad = r_quad[SC_STAGES-1];
    assign o_trig.s0   = r_sq;
    assign o_trig.c0   = r_cq;
    assign o_geom      = r_geom[SC_STAGES-1];

endmodule

[rtl/obc_corner.sv]
// ============================================================================
// obc_corner
// Five-stage back end: rotate, round, offset and saturate, then bounds tree.
// ============================================================================
module obc_corner (
    input  logic                         i_clk,
    input  logic [obc_pkg::CN_STAGES-1:0] i_en,
    input  obc_pkg::t_trig               i_trig,
    input  obc_pkg::t_geom               i_geom,
    output obc_pkg::t_box_res            o_res
);
    import obc_pkg::*;

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    // per corner: local x negative, local y negative (bit = corner code)
    localparam logic [3:0] LX_NEG = 4'b1001;
    localparam logic [3:0] LY_NEG = 4'b0011;

    localparam logic signed [48:0] RND_HALF = 49'sd8192;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
            r = v[31:0];
        end else if (v[35]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] smin(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return (b < a) ? b : a;
    endfunction

    function automatic logic signed [31:0] smax(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return (b > a) ? b : a;
    endfunction

    // stage 0: quadrant fold and the four products
    logic signed [15:0] w_s, w_c, n_sn, n_cs;
    logic signed [31:0] w_hw, w_hh;
    logic signed [47:0] r_a, r_b, r_c, r_d;
    logic signed [15:0] r_sn [4];
    logic signed [15:0] r_cs [4];
    logic signed [31:0] r_cx [2];
    logic signed [31:0] r_cy [2];

    assign w_s  = $signed(i_trig.s0);
    assign w_c  = $signed(i_trig.c0);
    assign w_hw = $signed({1'b0, i_geom.hw});
    assign w_hh = $signed({1'b0, i_geom.hh});

    always_comb begin
        case (i_trig.quad)
            QUAD_I:   begin n_sn = w_s;  n_cs = w_c;  end
            QUAD_II:  begin n_sn = w_c;  n_cs = -w_s; end
            QUAD_III: begin n_sn = -w_s; n_cs = -w_c; end
            QUAD_IV:  begin n_sn = -w_c; n_cs = w_s;  end
            default:  begin n_sn = w_s;  n_cs = w_c;  end
        endcase
    end

    // stage 1: corner sums with half-up rounding bias
    logic signed [34:0] n_rx [4];
    logic signed [34:0] n_ry [4];
    logic signed [34:0] r_rx [4];
    logic signed [34:0] r_ry [4];

    always_comb begin
        logic signed [48:0] ea, eb, ec, ed, sx, sy;
        ea = 49'(r_a);
        eb = 49'(r_b);
        ec = 49'(r_c);
        ed = 49'(r_d);
        for (int k = 0; k < 4; k++) begin
            sx = (LX_NEG[k] ? -ea : ea) + (LY_NEG[k] ? eb : -eb) + RND_HALF;
            sy = (LX_NEG[k] ? -ec : ec) + (LY_NEG[k] ? -ed : ed) + RND_HALF;
            n_rx[k] = sx[48:14];
            n_ry[k] = sy[48:14];
        end
    end

    // stage 2 onward
    logic signed [31:0] r_wx2 [4];
    logic signed [31:0] r_wy2 [4];
    logic signed [31:0] r_wx3 [4];
    logic signed [31:0] r_wy3 [4];
    logic signed [31:0] r_mnx [2];
    logic signed [31:0] r_mxx [2];
    logic signed [31:0] r_mny [2];
    logic signed [31:0] r_mxy [2];
    t_box_res           r_res;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a     <= 48'(w_hw) * 48'(n_cs);
            r_b     <= 48'(w_hh) * 48'(n_sn);
            r_c     <= 48'(w_hw) * 48'(n_sn);
            r_d     <= 48'(w_hh) * 48'(n_cs);
            r_sn[0] <= n_sn;
            r_cs[0] <= n_cs;
            r_cx[0] <= i_geom.cx;
            r_cy[0] <= i_geom.cy;
        end
        for (int k = 1; k < 4; k++) begin
            if (i_en[k]) begin
                r_sn[k] <= r_sn[k-1];
                r_cs[k] <= r_cs[k-1];
            end
        end
        if (i_en[1]) begin
            r_rx    <= n_rx;
            r_ry    <= n_ry;
            r_cx[1] <= r_cx[0];
            r_cy[1] <= r_cy[0];
        end
        if (i_en[2]) begin
            for (int k = 0; k < 4; k++) begin
                r_wx2[k] <= sat32(36'(r_rx[k]) + 36'(r_cx[1]));
                r_wy2[k] <= sat32(36'(r_ry[k]) + 36'(r_cy[1]));
            end
        end
        if (i_en[3]) begin
            r_wx3    <= r_wx2;
            r_wy3    <= r_wy2;
            r_mnx[0] <= smin(r_wx2[0], r_wx2[1]);
            r_mnx[1] <= smin(r_wx2[2], r_wx2[3]);
            r_mxx[0] <= smax(r_wx2[0], r_wx2[1]);
            r_mxx[1] <= smax(r_wx2[2], r_wx2[3]);
            r_mny[0] <= smin(r_wy2[0], r_wy2[1]);
            r_mny[1] <= smin(r_wy2[2], r_wy2[3]);
            r_mxy[0] <= smax(r_wy2[0], r_wy2[1]);
            r_mxy[1] <= smax(r_wy2[2], r_wy2[3]);
        end
        if (i_en[4]) begin
            for (int k = 0; k < 4; k++) begin
                r_res.wx[k] <= r_wx3[k];
                r_res.wy[k] <= r_wy3[k];
            end
            r_res.min_x <= smin(r_mnx[0], r_mnx[1]);
            r_res.max_x <= smax(r_mxx[0], r_mxx[1]);
            r_res.min_y <= smin(r_mny[0], r_mny[1]);
            r_res.max_y <= smax(r_mxy[0], r_mxy[1]);
            // rotated (-1,0) and (0,-1)
            r_res.nx0   <= -r_cs[3];
            r_res.ny0   <= -r_sn[3];
            r_res.nx1   <= r_sn[3];
            r_res.ny1   <= -r_cs[3];
        end
    end

    assign o_res = r_res;

endmodule

[rtl/obc_serial.sv]
// ============================================================================
// obc_serial
// Output register: holds one box and issues its four corner transactions.
// ============================================================================
module obc_serial (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  obc_pkg::t_box_res i_res,
    output logic              o_take,
    obc_corner_if.source      o_corner
);
    import obc_pkg::*;

    logic       r_busy;
    logic [1:0] r_idx;
    t_box_res   r_res;
    logic       w_fire;

    assign w_fire = r_busy & o_corner.ready;
    assign o_take = ~r_busy | (w_fire & (r_idx == CORNER_TL));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= CORNER_BL;
        end else if (o_take) begin
            r_busy <= i_valid;
            r_idx  <= CORNER_BL;
        end else if (w_fire) begin
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_res <= i_res;
        end
    end

    always_comb begin
        case (r_idx)
            CORNER_BL: begin
                o_corner.normal_x = r_res.nx0;
                o_corner.normal_y = r_res.ny0;
            end
            CORNER_BR: begin
                o_corner.normal_x = r_res.nx1;
                o_corner.normal_y = r_res.ny1;
            end
            default: begin
                o_corner.normal_x = '0;
                o_corner.normal_y = '0;
            end
        endcase
    end

    assign o_corner.valid        = r_busy;
    assign o_corner.corner_index = r_idx;
    assign o_corner.corner_x     = r_res.wx[r_idx];
    assign o_corner.corner_y     = r_res.wy[r_idx];
    assign o_corner.bound_min_x  = r_res.min_x;
    assign o_corner.bound_min_y  = r_res.min_y;
    assign o_corner.bound_max_x  = r_res.max_x;
    assign o_corner.bound_max_y  = r_res.max_y;
    assign o_corner.last         = (r_idx == CORNER_TL);

endmodule
